FILE: rtl/core/pidtaw_pkg.sv
// Package for the trapezoidal PID controller with back-calculation anti-windup.
// Holds register codes, reset values, sequencer types and default parameters.
// No dependencies.
package pidtaw_pkg;

    // Default parameters
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_AW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATE = 3'd6;

    // Register reset values
    localparam logic signed [31:0] GAIN_P_RST    = 32'sd65536;
    localparam logic signed [31:0] GAIN_I_RST    = 32'sd32768;
    localparam logic signed [31:0] GAIN_D_RST    = 32'sd3277;
    localparam logic signed [31:0] GAIN_AW_RST   = 32'sd6554;
    localparam logic [30:0]        OUT_LIMIT_RST = 31'd786432;
    localparam logic [31:0]        STEP_TIME_RST = 32'd4294967;
    localparam logic [30:0]        STEP_RATE_RST = 31'd65536000;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_ADD,
        ST_CLAMP,
        ST_DONE
    } state_t;

    // Multiplier operations, issued in this order
    typedef enum logic [2:0] {
        OP_KIDT,
        OP_P,
        OP_TRAP,
        OP_DK,
        OP_AW,
        OP_D
    } mul_op_t;

    // Adder operations, issued in this order
    typedef enum logic [1:0] {
        ADD_TRAP,
        ADD_AW,
        ADD_P,
        ADD_D
    } add_op_t;

endpackage

FILE: rtl/core/pid_trapezoid_antiwindup_unit.sv
// Top level of the trapezoidal PID controller with back-calculation anti-windup.
// One shared magnitude multiplier and one shared saturating adder under a sequencer.
// Depends on pidtaw_pkg.
//
//  channel   direction  handshake              payload
//  --------  ---------  ---------------------  ---------------------------------
//  s_        in         s_valid / s_ready      s_err_sample   (signed Q16.16)
//  m_        out        m_valid / m_ready      m_drive, m_saturated
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each request passes in order through six multiplies in the single 32x33 multiplier, a
// drain step, four passes through the saturating adder, a clamp and a final state that
// loads the result register. s_ready rises again in the cycle after the result is loaded,
// so a new request enters only after the last one is through. The final state holds
// while an earlier result still waits in the output register.
// aresetn is synchronous, active low; it restores register defaults and zeroes the
// integral, previous error and excess. cfg_ready is always high.
module pid_trapezoid_antiwindup_unit #(
    parameter int DATA_WIDTH = pidtaw_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = pidtaw_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // error sample channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [31:0]                  s_err_sample,
    // drive channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_drive,
    output logic                                m_saturated,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pidtaw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidtaw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Saturation width: the data width, capped at 32 bits.
    localparam int SAT_W   = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int PROD_W  = 65;
    localparam int SH_Q    = FRAC_BITS;
    localparam int SH_HALF = FRAC_BITS + 1;
    localparam int SH_KIDT = 32;
    localparam logic [PROD_W-1:0] MAG_MAX = PROD_W'((PROD_W'(1) << (SAT_W - 1)) - 1);
    localparam logic [PROD_W-1:0] MAG_MIN = PROD_W'(PROD_W'(1) << (SAT_W - 1));
    localparam logic signed [SAT_W-1:0] SAT_HI = {1'b0, {(SAT_W-1){1'b1}}};
    localparam logic signed [SAT_W-1:0] SAT_LO = {1'b1, {(SAT_W-1){1'b0}}};

    // ------------------------------------------------------------------
    // Saturating add/subtract on SAT_W-bit values
    // ------------------------------------------------------------------
    function automatic logic signed [SAT_W-1:0] sat_add(
        input logic signed [SAT_W-1:0] a,
        input logic signed [SAT_W-1:0] b,
        input logic                    sub
    );
        logic signed [SAT_W:0] s;
        s = sub ? ((SAT_W+1)'(a) - (SAT_W+1)'(b)) : ((SAT_W+1)'(a) + (SAT_W+1)'(b));
        if (s[SAT_W] != s[SAT_W-1]) begin
            return s[SAT_W] ? SAT_LO : SAT_HI;
        end
        return s[SAT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg, gain_aw_reg;
    logic [30:0]        out_limit_reg;
    logic [31:0]        step_time_reg;
    logic [30:0]        step_rate_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg    <= pidtaw_pkg::GAIN_P_RST;
            gain_i_reg    <= pidtaw_pkg::GAIN_I_RST;
            gain_d_reg    <= pidtaw_pkg::GAIN_D_RST;
            gain_aw_reg   <= pidtaw_pkg::GAIN_AW_RST;
            out_limit_reg <= pidtaw_pkg::OUT_LIMIT_RST;
            step_time_reg <= pidtaw_pkg::STEP_TIME_RST;
            step_rate_reg <= pidtaw_pkg::STEP_RATE_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pidtaw_pkg::CFG_GAIN_P:    gain_p_reg    <= signed'(cfg_data);
                pidtaw_pkg::CFG_GAIN_I:    gain_i_reg    <= signed'(cfg_data);
                pidtaw_pkg::CFG_GAIN_D:    gain_d_reg    <= signed'(cfg_data);
                pidtaw_pkg::CFG_GAIN_AW:   gain_aw_reg   <= signed'(cfg_data);
                pidtaw_pkg::CFG_OUT_LIMIT: out_limit_reg <= cfg_data[30:0];
                pidtaw_pkg::CFG_STEP_TIME: step_time_reg <= cfg_data;
                pidtaw_pkg::CFG_STEP_RATE: step_rate_reg <= cfg_data[30:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    pidtaw_pkg::state_t  state_reg, state_next;
    pidtaw_pkg::mul_op_t op_reg, op_next;
    pidtaw_pkg::add_op_t add_op_reg, add_op_next;
    pidtaw_pkg::mul_op_t prod_op_reg;
    logic                prod_vld_reg;

    logic s_fire, out_free;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pidtaw_pkg::ST_IDLE:  if (s_valid) state_next = pidtaw_pkg::ST_MUL;
            pidtaw_pkg::ST_MUL:   if (op_reg == pidtaw_pkg::OP_D) state_next = pidtaw_pkg::ST_DRAIN;
            pidtaw_pkg::ST_DRAIN: state_next = pidtaw_pkg::ST_ADD;
            pidtaw_pkg::ST_ADD:   if (add_op_reg == pidtaw_pkg::ADD_D) state_next = pidtaw_pkg::ST_CLAMP;
            pidtaw_pkg::ST_CLAMP: state_next = pidtaw_pkg::ST_DONE;
            pidtaw_pkg::ST_DONE:  if (out_free) state_next = pidtaw_pkg::ST_IDLE;
            default:              state_next = pidtaw_pkg::ST_IDLE;
        endcase
    end

    // Control decode
    logic issue_mul, finish;
    always_comb begin
        s_ready     = 1'b0;
        issue_mul   = 1'b0;
        finish      = 1'b0;
        op_next     = op_reg;
        add_op_next = add_op_reg;
        case (state_reg)
            pidtaw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                op_next = pidtaw_pkg::OP_KIDT;
            end
            pidtaw_pkg::ST_MUL: begin
                issue_mul = 1'b1;
                case (op_reg)
                    pidtaw_pkg::OP_KIDT: op_next = pidtaw_pkg::OP_P;
                    pidtaw_pkg::OP_P:    op_next = pidtaw_pkg::OP_TRAP;
                    pidtaw_pkg::OP_TRAP: op_next = pidtaw_pkg::OP_DK;
                    pidtaw_pkg::OP_DK:   op_next = pidtaw_pkg::OP_AW;
                    pidtaw_pkg::OP_AW:   op_next = pidtaw_pkg::OP_D;
                    default:             op_next = pidtaw_pkg::OP_D;
                endcase
            end
            pidtaw_pkg::ST_DRAIN: add_op_next = pidtaw_pkg::ADD_TRAP;
            pidtaw_pkg::ST_ADD: begin
                case (add_op_reg)
                    pidtaw_pkg::ADD_TRAP: add_op_next = pidtaw_pkg::ADD_AW;
                    pidtaw_pkg::ADD_AW:   add_op_next = pidtaw_pkg::ADD_P;
                    default:              add_op_next = pidtaw_pkg::ADD_D;
                endcase
            end
            pidtaw_pkg::ST_DONE: finish = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pidtaw_pkg::ST_IDLE;
            op_reg       <= pidtaw_pkg::OP_KIDT;
            add_op_reg   <= pidtaw_pkg::ADD_TRAP;
            prod_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            add_op_reg   <= add_op_next;
            prod_vld_reg <= issue_mul;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier: sign-magnitude, product registered
    // ------------------------------------------------------------------
    logic signed [31:0]        err_reg;
    logic signed [31:0]        last_err_reg;
    logic signed [SAT_W-1:0]   integ_acc_reg, excess_reg;
    logic signed [SAT_W-1:0]   kidt_reg, p_reg, trap_reg, dk_reg, aw_reg, d_reg;
    logic signed [SAT_W-1:0]   run_reg, clamped_reg;
    logic                      sat_flag_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic                      prod_neg_reg;

    logic signed [31:0] mul_a;
    logic signed [33:0] mul_b;
    logic [31:0]        a_mag;
    logic [32:0]        b_mag;

    always_comb begin
        case (op_reg)
            pidtaw_pkg::OP_KIDT: begin
                mul_a = gain_i_reg;
                mul_b = signed'({2'b00, step_time_reg});
            end
            pidtaw_pkg::OP_P: begin
                mul_a = gain_p_reg;
                mul_b = 34'(err_reg);
            end
            pidtaw_pkg::OP_TRAP: begin
                mul_a = 32'(kidt_reg);
                mul_b = 34'(err_reg) + 34'(last_err_reg);
            end
            pidtaw_pkg::OP_DK: begin
                mul_a = gain_d_reg;
                mul_b = 34'(err_reg) - 34'(last_err_reg);
            end
            pidtaw_pkg::OP_AW: begin
                mul_a = gain_aw_reg;
                mul_b = 34'(excess_reg);
            end
            default: begin
                mul_a = 32'(dk_reg);
                mul_b = signed'({3'b000, step_rate_reg});
            end
        endcase
        a_mag = mul_a[31] ? 32'(-mul_a) : 32'(mul_a);
        b_mag = mul_b[33] ? 33'(-mul_b) : 33'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (issue_mul) begin
            prod_reg     <= PROD_W'(a_mag) * PROD_W'(b_mag);
            prod_neg_reg <= mul_a[31] ^ mul_b[33];
            prod_op_reg  <= op_reg;
        end
    end

    // Truncate the magnitude, restore the sign, saturate.
    logic [PROD_W-1:0]       q_mag;
    logic [SAT_W-1:0]        q_lo;
    logic signed [SAT_W-1:0] term;

    always_comb begin
        case (prod_op_reg)
            pidtaw_pkg::OP_KIDT: q_mag = prod_reg >> SH_KIDT;
            pidtaw_pkg::OP_TRAP: q_mag = prod_reg >> SH_HALF;
            default:             q_mag = prod_reg >> SH_Q;
        endcase
        q_lo = q_mag[SAT_W-1:0];
        if (prod_neg_reg) begin
            term = (q_mag > MAG_MIN) ? SAT_LO : signed'(-q_lo);
        end else begin
            term = (q_mag > MAG_MAX) ? SAT_HI : signed'(q_lo);
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_vld_reg) begin
            case (prod_op_reg)
                pidtaw_pkg::OP_KIDT: kidt_reg <= term;
                pidtaw_pkg::OP_P:    p_reg    <= term;
                pidtaw_pkg::OP_TRAP: trap_reg <= term;
                pidtaw_pkg::OP_DK:   dk_reg   <= term;
                pidtaw_pkg::OP_AW:   aw_reg   <= term;
                default:             d_reg    <= term;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared saturating adder
    //   integ = (integ_acc + trap) - aw ; sum = (integ + p) + d ;
    //   excess = sum - clamped
    // ------------------------------------------------------------------
    logic signed [SAT_W-1:0] add_a, add_b, add_res;
    logic                    add_sub;

    always_comb begin
        add_a   = run_reg;
        add_b   = d_reg;
        add_sub = 1'b0;
        if (state_reg == pidtaw_pkg::ST_DONE) begin
            add_b   = clamped_reg;
            add_sub = 1'b1;
        end else begin
            case (add_op_reg)
                pidtaw_pkg::ADD_TRAP: begin
                    add_a = integ_acc_reg;
                    add_b = trap_reg;
                end
                pidtaw_pkg::ADD_AW: begin
                    add_b   = aw_reg;
                    add_sub = 1'b1;
                end
                pidtaw_pkg::ADD_P: add_b = p_reg;
                default:           add_b = d_reg;
            endcase
        end
        add_res = sat_add(add_a, add_b, add_sub);
    end

    // Clamp to the symmetric limit
    logic signed [32:0]      lim_x, sum_x;
    logic signed [SAT_W-1:0] clamp_val;
    logic                    clamp_hit;

    always_comb begin
        lim_x = signed'({2'b00, out_limit_reg});
        sum_x = 33'(run_reg);
        clamp_hit = 1'b1;
        if (sum_x > lim_x) begin
            clamp_val = SAT_W'(lim_x);
        end else if (sum_x < -lim_x) begin
            clamp_val = SAT_W'(-lim_x);
        end else begin
            clamp_val = run_reg;
            clamp_hit = 1'b0;
        end
    end

    // Payload registers of the working item
    logic signed [SAT_W-1:0] integ_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            err_reg <= s_err_sample;
        end
        if (state_reg == pidtaw_pkg::ST_ADD) begin
            run_reg <= add_res;
            if (add_op_reg == pidtaw_pkg::ADD_AW) begin
                integ_reg <= add_res;
            end
        end
        if (state_reg == pidtaw_pkg::ST_CLAMP) begin
            clamped_reg  <= clamp_val;
            sat_flag_reg <= clamp_hit;
        end
    end

    // Controller state: advance only when the result is committed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_acc_reg <= '0;
            last_err_reg  <= '0;
            excess_reg    <= '0;
        end else if (finish) begin
            integ_acc_reg <= integ_reg;
            last_err_reg  <= err_reg;
            excess_reg    <= add_res;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds the result until taken
    // ------------------------------------------------------------------
    logic                m_valid_reg;
    logic signed [31:0]  m_drive_reg;
    logic                m_saturated_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            m_drive_reg     <= 32'(clamped_reg);
            m_saturated_reg <= sat_flag_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_drive     = m_drive_reg;
    assign m_saturated = m_saturated_reg;

endmodule
